// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the zcp_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/zcp_pkg.sv =====
package zcp_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FILTER_LEN_DEFAULT = 7;
  localparam int WINDOW_BITS = 16;
  localparam int GAP_BITS = 16;
  localparam int PERIOD_BITS = 17;
  localparam int OUTCOME_BITS = 2;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [WINDOW_BITS-1:0] WINDOW_INIT = 16'd9000;
  localparam logic [SAMPLE_BITS-1:0] THRESH_INIT = 10'd495;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_CALIBRATE_MODE = 1'b1;

  localparam logic [OUTCOME_BITS-1:0] OUTCOME_PERIOD = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_NO_WIND = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_CALIBRATED = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   start_req;
  } sample_t;

  typedef struct packed {
    logic [OUTCOME_BITS-1:0] outcome;
    logic [PERIOD_BITS-1:0]  period_samples;
    logic [SAMPLE_BITS-1:0]  threshold_value;
  } result_t;

  typedef struct packed {
    logic [WINDOW_BITS-1:0] window_length;
    logic                   calibrate_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/zcp_regs.sv =====
module zcp_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [zcp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [zcp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [zcp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output zcp_pkg::cfg_t                       cfg
);

  logic [zcp_pkg::WINDOW_BITS-1:0] window_length;
  logic                            calibrate_mode;
  logic                            wr_en;
  logic                            reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= zcp_pkg::WINDOW_INIT;
      calibrate_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        zcp_pkg::REG_WINDOW_LENGTH: begin
          window_length <= pwdata[zcp_pkg::WINDOW_BITS-1:0];
        end
        zcp_pkg::REG_CALIBRATE_MODE: begin
          calibrate_mode <= pwdata[0];
        end
        default: begin
          window_length <= window_length;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      zcp_pkg::REG_WINDOW_LENGTH: begin
        prdata = zcp_pkg::APB_DATA_BITS'(window_length);
      end
      zcp_pkg::REG_CALIBRATE_MODE: begin
        prdata = zcp_pkg::APB_DATA_BITS'(calibrate_mode);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg.window_length = window_length;
  assign cfg.calibrate_mode = calibrate_mode;

endmodule

// ===== hw/rtl/zcp_core.sv =====
module zcp_core #(
  parameter int FILTER_LEN = zcp_pkg::FILTER_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  zcp_pkg::sample_t  item,
  input  zcp_pkg::cfg_t     cfg,
  output logic              res_valid,
  output zcp_pkg::result_t  res
);

  localparam int SB = zcp_pkg::SAMPLE_BITS;
  localparam int CNT_BITS = $clog2(FILTER_LEN + 1);
  localparam int MAJ_LIMIT = FILTER_LEN / 2;
  localparam logic [FILTER_LEN-1:0] HIST_INIT = FILTER_LEN'(8'h55);
  localparam logic [FILTER_LEN-1:0] RISE_PAT = FILTER_LEN'((1 << ((FILTER_LEN + 1) / 2)) - 1);
  localparam logic [FILTER_LEN-1:0] FALL_PAT = ~RISE_PAT;
  localparam logic [SB:0] LOW_INIT = (SB + 1)'(1) << SB;

  logic [FILTER_LEN-1:0]            compare_history, compare_history_next;
  logic [FILTER_LEN-1:0]            majority_history, majority_history_next;
  logic [1:0]                       crossings_seen, crossings_seen_next;
  logic [zcp_pkg::GAP_BITS-1:0]     gap_count, gap_count_next;
  logic [zcp_pkg::GAP_BITS-1:0]     previous_gap, previous_gap_next;
  logic [zcp_pkg::WINDOW_BITS-1:0]  samples_left, samples_left_next;
  logic                             window_active, window_active_next;
  logic [SB-1:0]                    learned_threshold, learned_threshold_next;
  logic [SB-1:0]                    highest_seen, highest_seen_next;
  logic [SB:0]                      lowest_seen, lowest_seen_next;

  always_comb begin
    logic                  cmp_bit;
    logic                  maj_bit;
    logic                  period_done;
    logic [CNT_BITS-1:0]   ones;
    logic [SB+1:0]         mid_sum;

    compare_history_next = compare_history;
    majority_history_next = majority_history;
    crossings_seen_next = crossings_seen;
    gap_count_next = gap_count;
    previous_gap_next = previous_gap;
    samples_left_next = samples_left;
    window_active_next = window_active;
    learned_threshold_next = learned_threshold;
    highest_seen_next = highest_seen;
    lowest_seen_next = lowest_seen;
    res_valid = 1'b0;
    res = '0;
    cmp_bit = 1'b0;
    maj_bit = 1'b0;
    period_done = 1'b0;
    ones = '0;
    mid_sum = '0;

    if (item.start_req) begin
      compare_history_next = HIST_INIT;
      majority_history_next = HIST_INIT;
      crossings_seen_next = '0;
      gap_count_next = '0;
      previous_gap_next = '0;
      highest_seen_next = '0;
      lowest_seen_next = LOW_INIT;
      samples_left_next = (cfg.window_length == '0) ?
                          zcp_pkg::WINDOW_BITS'(1) : cfg.window_length;
      window_active_next = 1'b1;
    end

    if (window_active_next) begin
      if (cfg.calibrate_mode) begin
        if (item.sample > highest_seen_next) begin
          highest_seen_next = item.sample;
        end
        if ({1'b0, item.sample} < lowest_seen_next) begin
          lowest_seen_next = {1'b0, item.sample};
        end
      end else begin
        cmp_bit = item.sample > learned_threshold;
        compare_history_next = {compare_history_next[FILTER_LEN-2:0], cmp_bit};
        for (int i = 0; i < FILTER_LEN; i++) begin
          ones = ones + CNT_BITS'(compare_history_next[i]);
        end
        maj_bit = ones > CNT_BITS'(MAJ_LIMIT);
        majority_history_next = {majority_history_next[FILTER_LEN-2:0], maj_bit};
        if (majority_history_next == RISE_PAT || majority_history_next == FALL_PAT) begin
          if (crossings_seen_next >= 2'd2) begin
            // Third crossing: the last two gaps make one full period.
            period_done = 1'b1;
            window_active_next = 1'b0;
            res_valid = 1'b1;
            res.outcome = zcp_pkg::OUTCOME_PERIOD;
            res.period_samples = zcp_pkg::PERIOD_BITS'(previous_gap_next) +
                                 zcp_pkg::PERIOD_BITS'(gap_count_next);
            res.threshold_value = learned_threshold;
          end else begin
            previous_gap_next = gap_count_next;
            gap_count_next = '0;
            crossings_seen_next = crossings_seen_next + 2'd1;
          end
        end else if (gap_count_next != '1) begin
          gap_count_next = gap_count_next + zcp_pkg::GAP_BITS'(1);
        end
      end

      if (!period_done) begin
        samples_left_next = samples_left_next - zcp_pkg::WINDOW_BITS'(1);
        if (samples_left_next == '0) begin
          window_active_next = 1'b0;
          res_valid = 1'b1;
          if (cfg.calibrate_mode) begin
            mid_sum = (SB + 2)'(highest_seen_next) + (SB + 2)'(lowest_seen_next);
            learned_threshold_next = mid_sum[SB:1];
            res.outcome = zcp_pkg::OUTCOME_CALIBRATED;
          end else begin
            res.outcome = zcp_pkg::OUTCOME_NO_WIND;
          end
          res.threshold_value = learned_threshold_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_history <= HIST_INIT;
      majority_history <= HIST_INIT;
      crossings_seen <= '0;
      gap_count <= '0;
      previous_gap <= '0;
      samples_left <= '0;
      window_active <= 1'b0;
      learned_threshold <= zcp_pkg::THRESH_INIT;
      highest_seen <= '0;
      lowest_seen <= LOW_INIT;
    end else if (step_en) begin
      compare_history <= compare_history_next;
      majority_history <= majority_history_next;
      crossings_seen <= crossings_seen_next;
      gap_count <= gap_count_next;
      previous_gap <= previous_gap_next;
      samples_left <= samples_left_next;
      window_active <= window_active_next;
      learned_threshold <= learned_threshold_next;
      highest_seen <= highest_seen_next;
      lowest_seen <= lowest_seen_next;
    end
  end

endmodule

// ===== hw/rtl/filtered_zero_crossing_period.sv =====
// Zero-crossing period detector with a majority filter.
// Sample channel: sample_valid/sample_ready/sample_data carry one converter
// reading per beat; start_req opens a new window at that sample.
// Result channel: result_valid/result_ready/result_data carry at most one
// result per sample: a period in samples, a window end without a period, or
// a finished calibration with the newly learned threshold.
// Configuration: APB-style port; window_length at byte address 0 and
// calibrate_mode at byte address 4; the user must see that they are written
// only while the block is idle, as the block does not enforce it. A sample's
// result, if any, is registered as the sample leaves the input register.
// One sample per cycle is sustained while the result side does not stall;
// the whole step (compare, history shifts, popcount, gap counting, min/max)
// is one pass of logic between the input register and the result register.
// On a receiver stall the result waits in the output register, the input
// register can hold one more, then sample_ready drops till the beat is taken.
// Reset (synchronous, active high) empties both registers, closes any open
// window, restores window_length 9000, measure mode and threshold 495.
module filtered_zero_crossing_period #(
  parameter int FILTER_LEN = zcp_pkg::FILTER_LEN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  zcp_pkg::sample_t                    sample_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output zcp_pkg::result_t                    result_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [zcp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [zcp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [zcp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  zcp_pkg::cfg_t    cfg;
  zcp_pkg::sample_t held_item;
  zcp_pkg::result_t core_res;
  logic             held_valid;
  logic             core_valid;
  logic             advance;

  zcp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held sample moves on when the output register is free or emptying.
  assign advance = held_valid && (!result_valid || result_ready);
  assign sample_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      held_item <= sample_data;
    end
  end

  zcp_core #(
    .FILTER_LEN (FILTER_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .item      (held_item),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      result_data <= core_res;
    end
  end

endmodule

// ===== hw/rtl/zcp_checker.sv =====
`include "assert_macros.svh"

module zcp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  input  logic                                sample_ready,
  input  zcp_pkg::sample_t                    sample_data,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  zcp_pkg::result_t                    result_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [zcp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [zcp_pkg::APB_DATA_BITS-1:0]   pwdata,
  input  logic [zcp_pkg::APB_DATA_BITS-1:0]   prdata,
  input  logic                                pready
);

  // Only a found period carries a nonzero sample count.
  `ASSERT_SAME(a_period_only_when_found,
    result_valid && result_data.outcome != zcp_pkg::OUTCOME_PERIOD,
    result_data.period_samples == '0, "period reported with a non-period outcome")

  // With the output register empty, the input side can always take a beat.
  `ASSERT_SAME(a_ready_when_empty, !result_valid, sample_ready,
    "sample_ready low while no result is pending")

  // A stalled result beat keeps its payload.
  `ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result_data), "stalled result changed or dropped")

  // Coming out of reset nothing is pending on the result side.
  `ASSERT_SAME(a_empty_after_reset, $fell(rst), !result_valid,
    "result pending right after reset")

endmodule

bind filtered_zero_crossing_period zcp_checker u_zcp_checker (.*);

// ===== verif/zcp_period_checker.sv =====
module zcp_period_checker
  import zcp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  input  logic                     sample_ready,
  input  sample_t                  sample_data,
  input  logic                     result_valid,
  input  logic                     result_ready,
  input  result_t                  result_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output int                       mismatches,
  output int                       results_owed
);

  localparam int HIST_BITS = FILTER_LEN_DEFAULT;
  localparam int MAJ_LIMIT = HIST_BITS / 2;

  typedef logic [HIST_BITS-1:0] hist_t;

  localparam hist_t HIST_INIT = 7'h55;
  localparam hist_t RISE_PAT = hist_t'((1 << ((HIST_BITS + 1) / 2)) - 1);
  localparam hist_t FALL_PAT = ~RISE_PAT;

  logic [WINDOW_BITS-1:0] win_len_reg;
  logic                   cal_mode_reg;

  hist_t                  cmp_hist;
  hist_t                  maj_hist;
  logic [1:0]             crossings;
  logic [GAP_BITS-1:0]    gap;
  logic [GAP_BITS-1:0]    last_gap;
  logic [WINDOW_BITS-1:0] left;
  logic                   window_open;
  logic [SAMPLE_BITS-1:0] thresh;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS:0]   trough;

  result_t owed_results[$];

  function automatic void clear_window();
    cmp_hist = HIST_INIT;
    maj_hist = HIST_INIT;
    crossings = '0;
    gap = '0;
    last_gap = '0;
    peak = '0;
    trough = (SAMPLE_BITS + 1)'(1) << SAMPLE_BITS;
  endfunction

  // Advances the window by one sample; returns 1 when the sample ends it.
  function automatic bit advance_window(input sample_t beat, output result_t res);
    logic                 cmp_bit;
    logic                 maj_bit;
    logic [SAMPLE_BITS+1:0] span_sum;
    res = '0;
    if (beat.start_req) begin
      clear_window();
      left = (win_len_reg == '0) ? WINDOW_BITS'(1) : win_len_reg;
      window_open = 1'b1;
    end
    if (!window_open) return 1'b0;

    if (cal_mode_reg) begin
      if (beat.sample > peak) peak = beat.sample;
      if ({1'b0, beat.sample} < trough) trough = {1'b0, beat.sample};
    end else begin
      cmp_bit = beat.sample > thresh;
      cmp_hist = {cmp_hist[HIST_BITS-2:0], cmp_bit};
      maj_bit = $countones(cmp_hist) > MAJ_LIMIT;
      maj_hist = {maj_hist[HIST_BITS-2:0], maj_bit};
      if (maj_hist == RISE_PAT || maj_hist == FALL_PAT) begin
        // The third crossing closes the window with the sum of the last two gaps.
        if (crossings >= 2) begin
          window_open = 1'b0;
          res.outcome = OUTCOME_PERIOD;
          res.period_samples = PERIOD_BITS'(last_gap) + PERIOD_BITS'(gap);
          res.threshold_value = thresh;
          return 1'b1;
        end
        last_gap = gap;
        gap = '0;
        crossings++;
      end else if (gap != '1) begin
        gap++;
      end
    end

    left--;
    if (left == '0) begin
      window_open = 1'b0;
      if (cal_mode_reg) begin
        span_sum = (SAMPLE_BITS + 2)'(peak) + (SAMPLE_BITS + 2)'(trough);
        thresh = span_sum[SAMPLE_BITS:1];
        res.outcome = OUTCOME_CALIBRATED;
      end else begin
        res.outcome = OUTCOME_NO_WIND;
      end
      res.threshold_value = thresh;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (rst) begin
      win_len_reg = WINDOW_INIT;
      cal_mode_reg = 1'b0;
      thresh = THRESH_INIT;
      left = '0;
      window_open = 1'b0;
      clear_window();
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_WINDOW_LENGTH, 2'b00}) win_len_reg = pwdata[WINDOW_BITS-1:0];
        else if (paddr == {REG_CALIBRATE_MODE, 2'b00}) cal_mode_reg = pwdata[0];
      end

      if (result_valid && result_ready) begin
        if (owed_results.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result beat: outcome %0d period %0d threshold %0d",
                     result_data.outcome, result_data.period_samples,
                     result_data.threshold_value);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (result_data.outcome !== want.outcome ||
              result_data.period_samples !== want.period_samples ||
              result_data.threshold_value !== want.threshold_value) begin
            if (mismatches < 10)
              $display("Result mismatch: expected outcome %0d period %0d threshold %0d,",
                       want.outcome, want.period_samples, want.threshold_value,
                       " got outcome %0d period %0d threshold %0d",
                       result_data.outcome, result_data.period_samples,
                       result_data.threshold_value);
            mismatches++;
          end
        end
      end

      if (sample_valid && sample_ready) begin
        if (advance_window(sample_data, fresh)) owed_results.push_back(fresh);
      end
      results_owed <= owed_results.size();
    end
  end

endmodule

// ===== verif/filtered_zero_crossing_period_tb.sv =====
module filtered_zero_crossing_period_tb;
  import zcp_pkg::*;

  localparam int ITEM_GOAL = 1500;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF = 400;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_ready;
  sample_t                  sample_data = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  result_t                  result_data;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int mismatches;
  int results_owed;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stretch_left = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  bit pressure_done = 1'b0;
  logic [SAMPLE_BITS-1:0] live_thresh = THRESH_INIT;

  filtered_zero_crossing_period dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_data(sample_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data(result_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  zcp_period_checker checker_i (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_data(sample_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data(result_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .mismatches(mismatches),
    .results_owed(results_owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stretches of different stall patterns, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) live_thresh <= result_data.threshold_value;
      if (stretch_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stretch_left <= $urandom_range(20, 200);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      if (hold_request && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_OFF;
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= (cycle_count % 3 != 0);
        endcase
      end
    end
  end

  task automatic put_sample(input logic [SAMPLE_BITS-1:0] value, input logic opens);
    int gap;
    sample_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    beat.sample = value;
    beat.start_req = opens;
    sample_valid <= 1'b1;
    sample_data <= beat;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    items_sent++;
  endtask

  // Lets in-flight samples drain and every owed result arrive.
  task automatic settle();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [APB_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int len, input bit mode);
    settle();
    set_reg(REG_WINDOW_LENGTH, APB_DATA_BITS'(len));
    set_reg(REG_CALIBRATE_MODE, APB_DATA_BITS'(mode));
  endtask

  // Square wave around the current threshold with random half periods,
  // occasional short glitches for the filter, and rare restarts.
  task automatic send_wave(input int count);
    int i;
    int half;
    bit level;
    logic [SAMPLE_BITS-1:0] v;
    level = 1'($urandom_range(0, 1));
    half = $urandom_range(4, 24);
    for (i = 0; i < count; i++) begin
      if (half == 0) begin
        level = !level;
        half = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      end
      if (level) v = (live_thresh == '1) ? live_thresh :
                     SAMPLE_BITS'($urandom_range(1023, live_thresh + 1));
      else v = SAMPLE_BITS'($urandom_range(live_thresh, 0));
      if ($urandom_range(0, 39) == 0) v = SAMPLE_BITS'($urandom_range(0, 1023));
      put_sample(v, i == 0 || $urandom_range(0, 99) == 0);
      half--;
    end
  endtask

  task automatic send_calibration(input int count);
    int i;
    int lo;
    int hi;
    case ($urandom_range(0, 9))
      0: begin lo = 0; hi = 0; end
      1: begin lo = 1023; hi = 1023; end
      2: begin lo = 0; hi = 1023; end
      default: begin lo = $urandom_range(50, 480); hi = $urandom_range(520, 980); end
    endcase
    for (i = 0; i < count; i++) put_sample(SAMPLE_BITS'($urandom_range(lo, hi)), i == 0);
  endtask

  initial begin
    int len;
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A sample with no window open is dropped.
    put_sample(10'd300, 1'b0);
    // A zero window length acts as a single-sample window.
    configure(0, 1'b0);
    put_sample(10'd1023, 1'b1);
    put_sample(10'd0, 1'b1);
    // Calibration at the sample extremes.
    configure(1, 1'b1);
    put_sample(10'd0, 1'b1);
    put_sample(10'd1023, 1'b1);
    configure(2, 1'b1);
    put_sample(10'd0, 1'b1);
    put_sample(10'd1023, 1'b0);
    // Mode flips inside a window; the last sample's mode picks the outcome.
    configure(3, 1'b0);
    put_sample(10'd600, 1'b1);
    put_sample(10'd100, 1'b0);
    settle();
    set_reg(REG_CALIBRATE_MODE, APB_DATA_BITS'(1));
    put_sample(10'd700, 1'b0);
    configure(3, 1'b1);
    put_sample(10'd10, 1'b1);
    put_sample(10'd20, 1'b0);
    settle();
    set_reg(REG_CALIBRATE_MODE, APB_DATA_BITS'(0));
    put_sample(10'd30, 1'b0);
    // A start inside an open window abandons it.
    configure(65535, 1'b0);
    put_sample(10'd700, 1'b1);
    put_sample(10'd800, 1'b0);
    put_sample(10'd5, 1'b1);
    put_sample(10'd6, 1'b0);
    send_wave(120);

    while (items_sent < ITEM_GOAL) begin
      if (!pressure_done && items_sent > 600) begin
        // Short windows while the result side holds off fill the block up.
        configure(5, 1'b0);
        hold_request <= 1'b1;
        for (i = 0; i < 80; i++)
          put_sample(SAMPLE_BITS'($urandom_range(0, 1023)), i % 5 == 0);
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 60);
          configure(len, 1'b1);
          send_calibration(len);
        end
        2: begin
          configure($urandom_range(1, 40), 1'($urandom_range(0, 1)));
          len = $urandom_range(20, 60);
          for (i = 0; i < len; i++)
            put_sample(SAMPLE_BITS'($urandom_range(0, 1023)), $urandom_range(0, 7) == 0);
        end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 65535;
            1: len = $urandom_range(1, 8);
            default: len = $urandom_range(16, 160);
          endcase
          configure(len, 1'b0);
          send_wave((len > 200) ? 200 : len);
        end
      endcase
    end

    settle();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/zcp_pkg.sv
hw/rtl/zcp_regs.sv
hw/rtl/zcp_core.sv
hw/rtl/filtered_zero_crossing_period.sv
hw/rtl/zcp_checker.sv
verif/zcp_period_checker.sv
verif/filtered_zero_crossing_period_tb.sv
